// ===== design/gnce_pkg.sv =====
`timescale 1ns / 1ps

package gnce_pkg;

  localparam int MAX_SPAN     = 8;
  localparam int MAX_GRID_DIM = 1024;

  localparam int POS_W   = 32;
  localparam int RAD_W   = 31;
  localparam int INV_W   = 32;
  localparam int CFGD_W  = 32;
  localparam int CFG_DIM_W = 11;
  localparam int IDX_W   = 20;
  localparam int COORD_W = $clog2(MAX_GRID_DIM);
  localparam int DIM_W   = COORD_W + 1;
  localparam int CELL_W  = POS_W + 2;

  // Lanes of the cell-coordinate front end
  localparam int NLANE   = 6;
  localparam int LANE_CX = 0;
  localparam int LANE_CY = 1;
  localparam int LANE_XL = 2;
  localparam int LANE_XH = 3;
  localparam int LANE_YL = 4;
  localparam int LANE_YH = 5;

  localparam logic [INV_W-1:0]     INV_RESET  = 32'd65536;
  localparam logic [CFG_DIM_W-1:0] COLS_RESET = 11'd64;
  localparam logic [CFG_DIM_W-1:0] ROWS_RESET = 11'd64;

  typedef enum logic [1:0] {
    CFG_INV_CELL_SIZE = 2'd0,
    CFG_GRID_COLUMNS  = 2'd1,
    CFG_GRID_ROWS     = 2'd2
  } cfg_idx_e;

  typedef logic signed [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [RAD_W-1:0]        radius;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             last;
    logic             outside;
    logic             truncated;
  } result_t;

  // Window of one item, handed from the clamp stages to the emitter
  typedef struct packed {
    logic [COORD_W-1:0] i0;
    logic [COORD_W-1:0] i1;
    logic [COORD_W-1:0] j0;
    logic [COORD_W-1:0] j1;
    logic [IDX_W-1:0]   base;
    logic               truncated;
    logic               outside;
  } win_t;

endpackage

// ===== design/gnce_cfg.sv =====
`timescale 1ns / 1ps

module gnce_cfg import gnce_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFGD_W-1:0]    cfg_data_i,
  output logic [INV_W-1:0]     inv_o,
  output logic [DIM_W-1:0]     cols_o,
  output logic [DIM_W-1:0]     rows_o
);

  logic [INV_W-1:0]     inv_q;
  logic [CFG_DIM_W-1:0] cols_q;
  logic [CFG_DIM_W-1:0] rows_q;

  function automatic logic [DIM_W-1:0] dim_of(logic [CFG_DIM_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (32'(r) > MAX_GRID_DIM) begin
      d = DIM_W'(MAX_GRID_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q  <= INV_RESET;
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_INV_CELL_SIZE: inv_q  <= cfg_data_i[INV_W-1:0];
        CFG_GRID_COLUMNS:  cols_q <= cfg_data_i[CFG_DIM_W-1:0];
        CFG_GRID_ROWS:     rows_q <= cfg_data_i[CFG_DIM_W-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign inv_o  = inv_q;
  assign cols_o = dim_of(cols_q);
  assign rows_o = dim_of(rows_q);

endmodule

// ===== design/gnce_front.sv =====
`timescale 1ns / 1ps

module gnce_front import gnce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  output logic             rdy_o,
  input  item_t            item_i,
  input  logic [INV_W-1:0] inv_i,
  output logic             vld_o,
  input  logic             rdy_i,
  output cell_t            cells_o [NLANE]
);

  logic                  s1_vld_q, s2_vld_q, s3_vld_q;
  logic                  en1, en2, en3;
  logic signed [POS_W:0] v   [NLANE];
  logic [POS_W-1:0]      mag_q  [NLANE];
  logic                  neg1_q [NLANE];
  logic [2*POS_W-1:0]    prod_q [NLANE];
  logic                  neg2_q [NLANE];
  cell_t                 cell_q [NLANE];
  logic signed [POS_W:0] px, py, rr;

  // Advance a stage when it is empty or its content moves on
  assign en3   = !s3_vld_q || rdy_i;
  assign en2   = !s2_vld_q || en3;
  assign en1   = !s1_vld_q || en2;
  assign rdy_o = en1;
  assign vld_o = s3_vld_q;

  assign px = {item_i.pos_x[POS_W-1], item_i.pos_x};
  assign py = {item_i.pos_y[POS_W-1], item_i.pos_y};
  assign rr = {2'b00, item_i.radius};

  assign v[LANE_CX] = px;
  assign v[LANE_CY] = py;
  assign v[LANE_XL] = px - rr;
  assign v[LANE_XH] = px + rr;
  assign v[LANE_YL] = py - rr;
  assign v[LANE_YH] = py + rr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= vld_i;
      if (en2) s2_vld_q <= s1_vld_q;
      if (en3) s3_vld_q <= s2_vld_q;
    end
  end

  for (genvar k = 0; k < NLANE; k++) begin : g_lane
    logic [POS_W:0]       absv;
    logic [2*POS_W:0]     rnd;
    logic [POS_W:0]       q_ceil;

    // Sign and magnitude: the magnitude of every lane stays below 2^32
    assign absv   = v[k][POS_W] ? ((POS_W+1)'(0) - v[k]) : v[k];
    // Floor of a negative value is minus the ceiling of its magnitude
    assign rnd    = {1'b0, prod_q[k]} + (2*POS_W+1)'(33'h0_FFFF_FFFF);
    assign q_ceil = rnd[2*POS_W:POS_W];

    always_ff @(posedge clk_i) begin
      if (en1) begin
        mag_q[k]  <= absv[POS_W-1:0];
        neg1_q[k] <= v[k][POS_W];
      end
      if (en2) begin
        prod_q[k] <= mag_q[k] * inv_i;
        neg2_q[k] <= neg1_q[k];
      end
      if (en3) begin
        cell_q[k] <= neg2_q[k] ? (CELL_W'(0) - {1'b0, q_ceil})
                               : {2'b00, prod_q[k][2*POS_W-1:POS_W]};
      end
    end

    assign cells_o[k] = cell_q[k];
  end

endmodule

// ===== design/gnce_window.sv =====
`timescale 1ns / 1ps

module gnce_window import gnce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  output logic             rdy_o,
  input  cell_t            cells_i [NLANE],
  input  logic [DIM_W-1:0] cols_i,
  input  logic [DIM_W-1:0] rows_i,
  output logic             vld_o,
  input  logic             rdy_i,
  output win_t             win_o
);

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
    logic               cut;
  } axis_t;

  logic  s4_vld_q, s5_vld_q;
  logic  en4, en5;
  axis_t ax, ay;
  logic  out_x, out_y, outside;
  win_t  w4_d, w4_q, w5_d, w5_q;
  logic [COORD_W+DIM_W-1:0] base_full;

  function automatic axis_t clamp_axis(cell_t lo_c, cell_t hi_c, logic [DIM_W-1:0] dim);
    cell_t              dmax;
    logic [COORD_W-1:0] a, b, d;
    axis_t              r;
    dmax  = cell_t'({{(CELL_W-DIM_W){1'b0}}, dim}) - cell_t'(1);
    a     = lo_c[CELL_W-1] ? '0 : lo_c[COORD_W-1:0];
    b     = (hi_c > dmax) ? dmax[COORD_W-1:0] : hi_c[COORD_W-1:0];
    d     = b - a;
    r.cut = d > COORD_W'(MAX_SPAN - 1);
    r.lo  = a;
    r.hi  = r.cut ? (a + COORD_W'(MAX_SPAN - 1)) : b;
    return r;
  endfunction

  assign en5   = !s5_vld_q || rdy_i;
  assign en4   = !s4_vld_q || en5;
  assign rdy_o = en4;
  assign vld_o = s5_vld_q;

  // Check the particle's own cell per axis
  assign out_x = cells_i[LANE_CX][CELL_W-1] ||
                 (cells_i[LANE_CX] >= cell_t'({{(CELL_W-DIM_W){1'b0}}, cols_i}));
  assign out_y = cells_i[LANE_CY][CELL_W-1] ||
                 (cells_i[LANE_CY] >= cell_t'({{(CELL_W-DIM_W){1'b0}}, rows_i}));
  assign outside = out_x || out_y;

  assign ax = clamp_axis(cells_i[LANE_XL], cells_i[LANE_XH], cols_i);
  assign ay = clamp_axis(cells_i[LANE_YL], cells_i[LANE_YH], rows_i);

  always_comb begin
    w4_d = '0;
    if (outside) begin
      // A single cell at index zero carries the flag
      w4_d.outside = 1'b1;
    end else begin
      w4_d.i0        = ax.lo;
      w4_d.i1        = ax.hi;
      w4_d.j0        = ay.lo;
      w4_d.j1        = ay.hi;
      w4_d.truncated = ax.cut || ay.cut;
    end
  end

  assign base_full = w4_q.j0 * cols_i;

  always_comb begin
    w5_d      = w4_q;
    w5_d.base = IDX_W'(base_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      if (en4) s4_vld_q <= vld_i;
      if (en5) s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) w4_q <= w4_d;
    if (en5) w5_q <= w5_d;
  end

  assign win_o = w5_q;

endmodule

// ===== design/gnce_emit.sv =====
`timescale 1ns / 1ps

module gnce_emit import gnce_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  output logic             rdy_o,
  input  win_t             win_i,
  input  logic [DIM_W-1:0] cols_i,
  output logic             strobe_o,
  output result_t          res_o
);

  logic               act_q, act_d;
  logic [COORD_W-1:0] i_q, i_d, j_q, j_d;
  win_t               w_q, w_d;
  logic [IDX_W-1:0]   row_q, row_d;
  logic               strobe_q;
  result_t            res_q, res_d;
  logic               row_end, fin, load;

  assign row_end = (i_q == w_q.i1);
  assign fin     = act_q && row_end && (j_q == w_q.j1);
  assign load    = vld_i && (!act_q || fin);
  assign rdy_o   = !act_q || fin;

  always_comb begin
    act_d = act_q;
    i_d   = i_q;
    j_d   = j_q;
    w_d   = w_q;
    row_d = row_q;
    if (load) begin
      act_d = 1'b1;
      w_d   = win_i;
      i_d   = win_i.i0;
      j_d   = win_i.j0;
      row_d = win_i.base;
    end else if (fin) begin
      act_d = 1'b0;
    end else if (act_q) begin
      if (row_end) begin
        // Wrap to the next row
        i_d   = w_q.i0;
        j_d   = j_q + COORD_W'(1);
        row_d = row_q + IDX_W'(cols_i);
      end else begin
        i_d = i_q + COORD_W'(1);
      end
    end
  end

  always_comb begin
    res_d.cell_index = row_q + IDX_W'(i_q);
    res_d.last       = fin;
    res_d.outside    = w_q.outside;
    res_d.truncated  = w_q.truncated;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      act_q    <= act_d;
      strobe_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q   <= i_d;
    j_q   <= j_d;
    w_q   <= w_d;
    row_q <= row_d;
    res_q <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ===== design/grid_neighbor_cell_enumerator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// item      in         start & !busy                  item_i (pos_x, pos_y, radius)
// result    out        res_strobe_o, one cycle each   res_o (cell_index, last, outside,
//                                                     truncated)
// config    in         cfg_valid_i & cfg_ready_o      cfg_index_i, cfg_data_i
//
// An item passes five pipeline stages (sign/magnitude, multiply by the reciprocal,
// floor, clamp, row base) and then the emitter, which walks the window one index
// per cycle into the output register. The emitter walks all W*H indexes of a window
// of W columns by H rows before it takes the next, which sets the sustained rate.
// Reset clears all valid bits and loads the register defaults; there is no clearing
// pass. The receiver cannot stall; busy rises when the stages fill behind the emitter.

module grid_neighbor_cell_enumerator import gnce_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  item_t             item_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CFGD_W-1:0] cfg_data_i,
  output logic              res_strobe_o,
  output result_t           res_o
);

  logic [INV_W-1:0] inv;
  logic [DIM_W-1:0] cols, rows;
  logic             front_rdy, front_vld;
  logic             win_rdy, win_vld;
  logic             emit_rdy;
  cell_t            cells [NLANE];
  win_t             win;

  // Configuration registers and dimension clamping
  gnce_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .inv_o       (inv),
    .cols_o      (cols),
    .rows_o      (rows)
  );

  // Hold off new items only when the first stage cannot advance
  assign busy = !front_rdy;

  // Six lanes map position and window edges to cell coordinates
  gnce_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (start),
    .rdy_o   (front_rdy),
    .item_i  (item_i),
    .inv_i   (inv),
    .vld_o   (front_vld),
    .rdy_i   (win_rdy),
    .cells_o (cells)
  );

  // Outside check, clamp to grid and span, row base of the first row
  gnce_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (front_vld),
    .rdy_o   (win_rdy),
    .cells_i (cells),
    .cols_i  (cols),
    .rows_i  (rows),
    .vld_o   (win_vld),
    .rdy_i   (emit_rdy),
    .win_o   (win)
  );

  // Walk the window row by row, one index per cycle
  gnce_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (win_vld),
    .rdy_o    (emit_rdy),
    .win_i    (win),
    .cols_i   (cols),
    .strobe_o (res_strobe_o),
    .res_o    (res_o)
  );

endmodule
